>>> rtl/fpba_pkg.sv
// shared types and constants of the fit-policy block allocator
// depends on nothing; imported by the allocator top level
package fpba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_BITS    = 16;
  localparam int SIZE_W       = 16;
  localparam int HEADER_BYTES = 32;
  localparam int ARENA_RESET  = 4096;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_COUNT  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_HDL  = 2'd3
  } status_t;

  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_ARENA_BYTES = 1'b1;

  // one table entry: used mark, payload size, header offset
  typedef struct packed {
    logic                 used;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/fit_policy_block_allocator_top.sv
// fit-policy block allocator top level: sequencer around the block table ram
// depends on fpba_pkg and fpba_ram
//
// Usage: one operation beat on in_* (allocate, free, count) yields one result
// beat on out_*. Registers are written on cfg_* while the block is idle:
// index 0 selects best fit (0) or worst fit (1), index 1 sets the arena size
// and resets the table to one free block at offset 0.
// Sequence: every operation first reads all count valid entries through the
// single ram read port, one per cycle. A successful allocate then moves the
// entries above the chosen one up by one, one entry a cycle, and then writes
// the new free remainder above it and the chosen entry. A free walks the free
// neighbors on both sides one per cycle and then moves the entries above the
// merged run down.
// One item is in work at a time; in_tready is high only when idle.
// Reset: after rst_n one cycle writes entry 0 with the 4096 byte arena.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile, and its result waits until out_tready takes the first.
module fit_policy_block_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: opcode[1:0], request_bytes[17:2], handle_in[33:18]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: status[1:0], handle_out[17:2], block_bytes[33:18], frag_count[40:34]
  output logic [47:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);
  import fpba_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_WR_NEW, S_WR_PICK,
    S_RMERGE, S_LMERGE, S_WR_LO, S_COMPACT, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic                 policy_r, policy_nxt;
  logic [SIZE_W-1:0]    arena_r, arena_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  opcode_t              op_r, op_nxt;
  logic [15:0]          req_r, req_nxt;
  logic [15:0]          hdl_r, hdl_nxt;
  logic [CNT_W-1:0]     a_r, a_nxt;
  logic [IDX_W-1:0]     e_r, e_nxt;
  logic                 v_r, v_nxt;
  logic                 found_r, found_nxt;
  logic                 stop_r, stop_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_W-1:0]    keep_r, keep_nxt;
  logic [ADDR_BITS-1:0] poff_r, poff_nxt;
  logic [IDX_W-1:0]     lo_r, lo_nxt;
  logic [IDX_W-1:0]     hi_r, hi_nxt;
  logic [SIZE_W:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]     frag_r, frag_nxt;
  status_t              rs_r, rs_nxt;
  logic [15:0]          rh_r, rh_nxt;
  logic [15:0]          rb_r, rb_nxt;
  logic [47:0]          out_r, out_nxt;
  logic                 ov_r, ov_nxt;

  logic                 we;
  logic [IDX_W-1:0]     wa;
  entry_t               wd;
  logic [IDX_W-1:0]     ra;
  entry_t               rd;
  logic [ENTRY_W-1:0]   rd_raw;

  logic [SIZE_W:0]      rnd;
  logic [SIZE_W+1:0]    need;
  logic                 fits;
  logic [SIZE_W-1:0]    left;
  logic                 better;
  logic [IDX_W-1:0]     gap;

  fpba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENTRY_W)) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra),
    .rd  (rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  // allocate fit test on the entry just read
  assign rnd    = ({1'b0, req_r} + 17'd3) & ~17'd3;
  assign need   = {1'b0, rnd} + 18'(HEADER_BYTES);
  assign fits   = !rd.used && ({2'b00, rd.size} > need);
  assign left   = rd.size - rnd[SIZE_W-1:0];
  assign better = policy_r ? (left > keep_r) : (left < keep_r);
  assign gap    = hi_r - lo_r;

  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tdata  = out_r;
  assign out_tvalid = ov_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    policy_nxt = policy_r;
    arena_nxt  = arena_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    req_nxt    = req_r;
    hdl_nxt    = hdl_r;
    a_nxt      = a_r;
    e_nxt      = e_r;
    v_nxt      = 1'b0;
    found_nxt  = found_r;
    stop_nxt   = stop_r;
    pick_nxt   = pick_r;
    keep_nxt   = keep_r;
    poff_nxt   = poff_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    sum_nxt    = sum_r;
    frag_nxt   = frag_r;
    rs_nxt     = rs_r;
    rh_nxt     = rh_r;
    rb_nxt     = rb_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ra         = a_r[IDX_W-1:0];

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        we        = 1'b1;
        wd.offset = '0;
        wd.size   = arena_r;
        wd.used   = 1'b0;
        count_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_addr == CFG_FIT_POLICY) begin
            policy_nxt = cfg_data[0];
          end else begin
            arena_nxt = cfg_data;
            state_nxt = S_INIT;
          end
        end else if (in_tvalid) begin
          op_nxt    = opcode_t'(in_tdata[1:0]);
          req_nxt   = in_tdata[17:2];
          hdl_nxt   = in_tdata[33:18];
          a_nxt     = '0;
          found_nxt = 1'b0;
          keep_nxt  = '0;
          frag_nxt  = '0;
          rs_nxt    = ST_OK;
          rh_nxt    = '0;
          rb_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end

      // one read a cycle over all valid entries
      S_SCAN: begin
        if (a_r < count_r) begin
          v_nxt = 1'b1;
          e_nxt = a_r[IDX_W-1:0];
          a_nxt = a_r + CNT_W'(1);
        end
        if (v_r) begin
          case (op_r)
            OP_ALLOC: begin
              if (fits && (!found_r || better)) begin
                found_nxt = 1'b1;
                pick_nxt  = e_r;
                keep_nxt  = left;
                poff_nxt  = rd.offset;
              end
            end
            OP_FREE: begin
              if (!found_r && (rd.offset == hdl_r)) begin
                found_nxt = 1'b1;
                lo_nxt    = e_r;
                hi_nxt    = e_r;
                sum_nxt   = {1'b0, rd.size};
                poff_nxt  = rd.offset;
              end
            end
            OP_COUNT: begin
              if (!rd.used && (rd.size < req_r)) begin
                frag_nxt = frag_r + CNT_W'(1);
              end
            end
            default: ;
          endcase
        end else if (a_r >= count_r) begin
          stop_nxt = 1'b0;
          case (op_r)
            OP_ALLOC: begin
              if (!found_r) begin
                rs_nxt    = ST_NO_FIT;
                state_nxt = S_FIN;
              end else if (count_r >= CNT_W'(MAX_BLOCKS)) begin
                rs_nxt    = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                a_nxt     = count_r - CNT_W'(1);
                state_nxt = S_SHIFT;
              end
            end
            OP_FREE: begin
              if (!found_r) begin
                rs_nxt    = ST_BAD_HDL;
                state_nxt = S_FIN;
              end else begin
                a_nxt     = {1'b0, lo_r} + CNT_W'(1);
                state_nxt = S_RMERGE;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // move entries above the pick up by one, top first
      S_SHIFT: begin
        if (v_r) begin
          we = 1'b1;
          wa = e_r + IDX_W'(1);
          wd = rd;
        end
        if (a_r[IDX_W-1:0] != pick_r) begin
          v_nxt = 1'b1;
          e_nxt = a_r[IDX_W-1:0];
          a_nxt = a_r - CNT_W'(1);
        end else if (!v_r) begin
          state_nxt = S_WR_NEW;
        end
      end

      S_WR_NEW: begin
        we        = 1'b1;
        wa        = pick_r + IDX_W'(1);
        wd.offset = poff_r + ADDR_BITS'(HEADER_BYTES) + rnd[ADDR_BITS-1:0];
        wd.size   = keep_r - SIZE_W'(HEADER_BYTES);
        wd.used   = 1'b0;
        state_nxt = S_WR_PICK;
      end

      S_WR_PICK: begin
        we        = 1'b1;
        wa        = pick_r;
        wd.offset = poff_r;
        wd.size   = rnd[SIZE_W-1:0];
        wd.used   = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        rh_nxt    = poff_r;
        rb_nxt    = rnd[15:0];
        state_nxt = S_FIN;
      end

      // absorb free neighbors above the freed entry
      S_RMERGE: begin
        if (!stop_r && (a_r < count_r)) begin
          v_nxt = 1'b1;
          e_nxt = a_r[IDX_W-1:0];
          a_nxt = a_r + CNT_W'(1);
        end
        if (v_r && !stop_r) begin
          if (!rd.used) begin
            sum_nxt = sum_r + {1'b0, rd.size} + (SIZE_W+1)'(HEADER_BYTES);
            hi_nxt  = e_r;
          end else begin
            stop_nxt = 1'b1;
            v_nxt    = 1'b0;
          end
        end
        if (stop_r || (!v_r && (a_r >= count_r))) begin
          v_nxt     = 1'b0;
          stop_nxt  = 1'b0;
          a_nxt     = {1'b0, lo_r} - CNT_W'(1);
          state_nxt = S_LMERGE;
        end
      end

      // absorb free neighbors below, walking down
      S_LMERGE: begin
        if (!stop_r && (a_r < count_r)) begin
          v_nxt = 1'b1;
          e_nxt = a_r[IDX_W-1:0];
          a_nxt = a_r - CNT_W'(1);
        end
        if (v_r && !stop_r) begin
          if (!rd.used) begin
            sum_nxt  = sum_r + {1'b0, rd.size} + (SIZE_W+1)'(HEADER_BYTES);
            lo_nxt   = e_r;
            poff_nxt = rd.offset;
          end else begin
            stop_nxt = 1'b1;
            v_nxt    = 1'b0;
          end
        end
        if (stop_r || (!v_r && (a_r >= count_r))) begin
          v_nxt     = 1'b0;
          stop_nxt  = 1'b0;
          state_nxt = S_WR_LO;
        end
      end

      S_WR_LO: begin
        we        = 1'b1;
        wa        = lo_r;
        wd.offset = poff_r;
        wd.size   = sum_r[SIZE_W-1:0];
        wd.used   = 1'b0;
        a_nxt     = {1'b0, hi_r} + CNT_W'(1);
        state_nxt = (gap == '0) ? S_FIN : S_COMPACT;
      end

      // close the gap left by the merged run
      S_COMPACT: begin
        if (v_r) begin
          we = 1'b1;
          wa = e_r - gap;
          wd = rd;
        end
        if (a_r < count_r) begin
          v_nxt = 1'b1;
          e_nxt = a_r[IDX_W-1:0];
          a_nxt = a_r + CNT_W'(1);
        end else if (!v_r) begin
          count_nxt = count_r - {1'b0, gap};
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!ov_r || out_tready) begin
          out_nxt   = {7'd0, frag_r, rb_r, rh_r, rs_r};
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      policy_r <= 1'b0;
      arena_r  <= SIZE_W'(ARENA_RESET);
      count_r  <= CNT_W'(1);
      ov_r     <= 1'b0;
      v_r      <= 1'b0;
      stop_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      policy_r <= policy_nxt;
      arena_r  <= arena_nxt;
      count_r  <= count_nxt;
      ov_r     <= ov_nxt;
      v_r      <= v_nxt;
      stop_r   <= stop_nxt;
      found_r  <= found_nxt;
    end
    op_r   <= op_nxt;
    req_r  <= req_nxt;
    hdl_r  <= hdl_nxt;
    a_r    <= a_nxt;
    e_r    <= e_nxt;
    pick_r <= pick_nxt;
    keep_r <= keep_nxt;
    poff_r <= poff_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    sum_r  <= sum_nxt;
    frag_r <= frag_nxt;
    rs_r   <= rs_nxt;
    rh_r   <= rh_nxt;
    rb_r   <= rb_nxt;
    out_r  <= out_nxt;
  end

  // table fill stays within its bounds
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  // an upward move never writes above index count, one past the current fill
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (we && (state_r == S_SHIFT)) |-> ({1'b0, wa} <= count_r))
    else $error("shift write beyond table fill");

  // an accepted beat always starts a table scan
  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_SCAN))
    else $error("accepted beat did not start a scan");

endmodule

>>> rtl/fpba_ram.sv
// block table storage: one write port, one read port, registered read data
// depends on nothing but its parameters
module fpba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule
